>>> sv/sm4sb_pkg.sv
// ----------------------------------------------------------------------------
// SM4 S-box package
// Field and affine constants, sequencer state type and the affine map.
// ----------------------------------------------------------------------------
package sm4sb_pkg;

  localparam logic [7:0] AFFINE_ROW = 8'hA7;
  localparam logic [7:0] AFFINE_ADD = 8'hD3;
  localparam logic [8:0] FIELD_POLY = 9'h1F5;
  localparam logic [7:0] MSB_MASK   = 8'h80;

  // v^254 as six (square, multiply) pairs and one final square
  localparam int unsigned         INV_STEPS = 13;
  localparam int unsigned         STEP_W    = $clog2(INV_STEPS);
  localparam logic [STEP_W-1:0]   LAST_STEP = STEP_W'(INV_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } sm4sb_state_e;

  // Bit i is the parity of v masked by the row rotated left i places
  function automatic logic [7:0] affine_map(input logic [7:0] v);
    logic [7:0] row;
    logic [7:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      row    = (AFFINE_ROW << i) | (AFFINE_ROW >> (8 - i));
      res[i] = ^(v & row);
    end
    return res ^ AFFINE_ADD;
  endfunction

endpackage

>>> sv/sm4sb_in_if.sv
// ----------------------------------------------------------------------------
// SM4 S-box input channel
// Valid/ready request channel carrying one byte to substitute.
// ----------------------------------------------------------------------------
interface sm4sb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

>>> sv/sm4sb_out_if.sv
// ----------------------------------------------------------------------------
// SM4 S-box output channel
// Valid/ready request channel carrying one substituted byte.
// ----------------------------------------------------------------------------
interface sm4sb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;

  modport source (output valid, output byte_out, input ready);
  modport sink   (input valid, input byte_out, output ready);
endinterface

>>> sv/sm4sb_gf_mul.sv
// ----------------------------------------------------------------------------
// SM4 S-box field multiplier
// GF(2^8) product modulo x^8+x^7+x^6+x^5+x^4+x^2+1, shift-and-add form.
// ----------------------------------------------------------------------------
module sm4sb_gf_mul
  import sm4sb_pkg::*;
(
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  output logic [7:0] p_o
);

  always_comb begin
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a_i;
    for (int i = 0; i < 8; i++) begin
      if (b_i[i]) begin
        acc = acc ^ sh;
      end
      // reduce when the shifted operand overflows past bit 7
      sh = ((sh & MSB_MASK) != '0) ? ({sh[6:0], 1'b0} ^ FIELD_POLY[7:0])
                                   : {sh[6:0], 1'b0};
    end
    p_o = acc;
  end

endmodule

>>> sv/sm4_sbox_affine_inverse_unit.sv
// ----------------------------------------------------------------------------
// SM4 S-box, affine-inverse-affine
// One shared GF(2^8) multiplier forms the inverse as v^254 under a sequencer.
// ----------------------------------------------------------------------------
// The sequencer runs 13 multiplier steps; the last one stalls while the output is full.
// A new byte is taken only in idle, after the previous one has finished.
// A finished byte waits in the output register while the next one runs.
// Reset (rst_ni low, asynchronous) empties the output and returns to idle.
module sm4_sbox_affine_inverse_unit
  import sm4sb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sm4sb_in_if.sink    in_i,
  sm4sb_out_if.source out_o
);

  sm4sb_state_e      state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [7:0]        v_q, v_d;
  logic [7:0]        r_q, r_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic [7:0]        mul_b;
  logic [7:0]        mul_p;
  logic              in_fire;
  logic              finish;

  // even steps square, odd steps multiply by the affine-mapped input
  assign mul_b = step_q[0] ? v_q : r_q;

  sm4sb_gf_mul u_mul (
    .a_i (r_q),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign in_i.ready     = (state_q == ST_IDLE);
  assign in_fire        = in_i.valid && in_i.ready;
  assign finish         = (state_q == ST_RUN) && (step_q == LAST_STEP)
                          && (!out_valid_q || out_o.ready);
  assign out_o.valid    = out_valid_q;
  assign out_o.byte_out = out_data_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    v_d         = v_q;
    r_d         = r_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          v_d     = affine_map(in_i.byte_in);
          r_d     = affine_map(in_i.byte_in);
          step_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q != LAST_STEP) begin
          r_d    = mul_p;
          step_d = step_q + 1'b1;
        end else if (finish) begin
          // hold the last square until the output register is free
          out_valid_d = 1'b1;
          out_data_d  = affine_map(mul_p);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    r_q        <= r_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("sequencer did not start at step zero");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= LAST_STEP))
    else $error("step counter ran past the last step");

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RUN) && ($past(step_q) == LAST_STEP))
    else $error("result issued before the power chain completed");

  a_nonzero_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (v_q != '0)) |-> (r_q != '0))
    else $error("power of a nonzero field element became zero");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 S-box unit testbench
// Sends bytes to the affine-inverse-affine S-box and checks every output byte
// against an independent GF(2^8) predictor, under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench
  import sm4sb_pkg::*;
();

  localparam int SBOX_LATENCY   = 14;
  localparam int SETTLE_CYCLES  = 3 * SBOX_LATENCY;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 15;

  typedef struct {
    logic [7:0] byte_in;
    logic [7:0] byte_out;
  } sbox_req_t;

  logic clk_i;
  logic rst_ni;

  sm4sb_in_if  in_if ();
  sm4sb_out_if out_if ();

  sm4_sbox_affine_inverse_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sbox_req_t  pending_sbox[$];
  int         mismatch_cnt = 0;
  int         quiet_cycles = 0;
  int         hold_req     = 0;
  int         hold_left    = 0;
  bit         steady       = 1'b0;
  logic [7:0] zero_preimage;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Bit i is the parity of v under the row rotated left by i
  function automatic logic [7:0] affine_xform(input logic [7:0] v);
    logic [15:0] row2;
    logic [7:0]  res;
    row2 = {AFFINE_ROW, AFFINE_ROW};
    res  = '0;
    for (int i = 0; i < 8; i++) begin
      res[i] = ^(v & row2[8-i +: 8]);
    end
    return res ^ AFFINE_ADD;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sh;
    logic [7:0] acc;
    sh  = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc ^= sh[7:0];
      end
      sh = sh << 1;
      if (sh[8]) begin
        sh ^= FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // Search for the inverse; zero has none and maps to zero
  function automatic logic [7:0] gf_inverse(input logic [7:0] v);
    logic [7:0] inv;
    inv = '0;
    if (v != 8'h00) begin
      for (int c = 1; c < 256; c++) begin
        if (gf_mul(v, 8'(c)) == 8'h01) begin
          inv = 8'(c);
        end
      end
    end
    return inv;
  endfunction

  function automatic logic [7:0] sbox_expected(input logic [7:0] x);
    return affine_xform(gf_inverse(affine_xform(x)));
  endfunction

  // Offer one byte, possibly after random idle cycles; valid stays high on return
  task automatic send_byte(input logic [7:0] b);
    sbox_req_t req;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    req.byte_in  = b;
    req.byte_out = sbox_expected(b);
    pending_sbox.push_back(req);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_sbox.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [7:0] walk;
    for (int x = 0; x < 256; x++) begin
      if (affine_xform(8'(x)) == 8'h00) begin
        zero_preimage = 8'(x);
      end
    end
    // affine image zero: inverse of zero taken as zero
    send_byte(zero_preimage);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFE);
    walk = 8'h01;
    for (int i = 0; i < 8; i++) begin
      send_byte(walk);
      send_byte(~walk);
      walk = walk << 1;
    end
    send_byte(zero_preimage);
    wait_drained();
  endtask

  task automatic test_full_sweep();
    logic [7:0] order[256];
    logic [7:0] tmp;
    int         j;
    for (int i = 0; i < 256; i++) begin
      order[i] = 8'(i);
    end
    for (int i = 255; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      send_byte(order[i]);
    end
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    hold_req = HOLD_OFF_LEN;
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (100) send_byte(8'($urandom_range(0, 255)));
    steady = 1'b0;
  endtask

  task automatic test_random();
    repeat (450) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Output side: long hold-offs, random stalls, none while steady
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_sbox.size() == 0) begin
        $error("byte_out unexpected: expected none, actual %02h", out_if.byte_out);
        mismatch_cnt++;
      end else begin
        sbox_req_t req;
        req = pending_sbox.pop_front();
        if (out_if.byte_out !== req.byte_out) begin
          $error("byte_out (byte_in %02h): expected %02h, actual %02h",
                 req.byte_in, req.byte_out, out_if.byte_out);
          mismatch_cnt++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.byte_in = 8'h00;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_sweep();
    test_output_hold_off();
    test_back_to_back();
    test_random();
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
